// File: design/cle_pkg.sv
// Shared constants and types for the command list engine.
package cle_pkg;
   localparam int CAPACITY_DEF = 16;
   localparam int ID_BITS_DEF = 32;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int DEST_W = 2;
   localparam int COORD_W = 64;
   localparam int OUT_ID_W = 32;
   localparam int IN_ID_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

   localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic [DEST_W-1:0] DEST_MASTER = 2'd0;
   localparam logic [DEST_W-1:0] DEST_NAV = 2'd1;
   localparam logic [DEST_W-1:0] DEST_CAM = 2'd2;
   localparam logic [DEST_W-1:0] DEST_NONE = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic at_head;
      logic [OUT_ID_W-1:0] new_id;
      logic more_left;
      logic msg_valid;
      logic msg_kind;
      logic [DEST_W-1:0] destination;
      logic [COORD_W-1:0] out_lat;
      logic [COORD_W-1:0] out_lon;
   } rsp_type;
endpackage

// File: design/command_list_engine.sv
// Top level of the command list engine: sequencer around the entry memory.
// The engine takes a new item only when idle and no result is pending.
// Insert, unless it goes to the head, and delete walk the linked list one
// entry at a time, with a memory read step then a compare step for each
// entry; the walk goes through the single read port of the entry memory.
// Flush and reset set back the slot-used flags, head, last popped id and id
// counter; there is no memory clearing pass.
// A finished result is held in an output register until taken.
module command_list_engine #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF,
   parameter int ID_BITS = cle_pkg::ID_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [cle_pkg::FUNC_W-1:0] req_func,
   input logic [cle_pkg::IN_ID_W-1:0] req_after_id,
   input logic [cle_pkg::IN_ID_W-1:0] req_target_id,
   input logic req_cmd_kind,
   input logic [cle_pkg::COORD_W-1:0] req_lat_word,
   input logic [cle_pkg::COORD_W-1:0] req_lon_word,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [cle_pkg::STAT_W-1:0] rsp_status,
   output logic rsp_at_head,
   output logic [cle_pkg::OUT_ID_W-1:0] rsp_new_id,
   output logic rsp_more_left,
   output logic rsp_msg_valid,
   output logic rsp_msg_kind,
   output logic [cle_pkg::DEST_W-1:0] rsp_destination,
   output logic [cle_pkg::COORD_W-1:0] rsp_out_lat,
   output logic [cle_pkg::COORD_W-1:0] rsp_out_lon
);
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = cle_pkg::COORD_W;
   localparam int EW = ID_BITS + 1 + 2 * CW + IW;
   localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);
   localparam int SW = $clog2(CAPACITY + 2);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_RD = 4'd2;
   localparam logic [3:0] S_CHK = 4'd3;
   localparam logic [3:0] S_WRN = 4'd4;
   localparam logic [3:0] S_POPW = 4'd5;
   localparam logic [3:0] S_POPN = 4'd6;
   localparam logic [3:0] S_DELR = 4'd7;
   localparam logic [3:0] S_DELW = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [IW-1:0] head_ff, head_in;
   logic [ID_BITS-1:0] idc_ff, idc_in, last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   cle_pkg::rsp_type rsp_ff, rsp_in;

   logic [cle_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [ID_BITS-1:0] key_ff, key_in;
   logic kind_ff, kind_in;
   logic [CW-1:0] lat_ff, lat_in, lon_ff, lon_in;
   logic [IW-1:0] cur_ff, cur_in, prev_ff, prev_in, slot_ff, slot_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [EW-1:0] ent_ff, ent_in;

   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;

   logic [ID_BITS-1:0] rd_id;
   logic rd_kind;
   logic [CW-1:0] rd_lat, rd_lon;
   logic [IW-1:0] rd_next, rd_follow;
   logic [IW-1:0] free_idx, head_v;
   logic [EW-1:0] new_ent;

   cle_store #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_store (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   function automatic logic valid_idx(input logic [IW-1:0] i, input logic [CAPACITY-1:0] u);
      logic r;
      r = 1'b0;
      if (i < IW'(CAPACITY)) begin
         r = u[i[AW-1:0]];
      end
      return r;
   endfunction

   assign {rd_id, rd_kind, rd_lat, rd_lon, rd_next} = rd_data;
   assign rd_follow = valid_idx(rd_next, used_ff) ? rd_next : NULL_IDX;
   assign head_v = valid_idx(head_ff, used_ff) ? head_ff : NULL_IDX;
   assign new_ent = {idc_ff, kind_ff, lat_ff, lon_ff, NULL_IDX};

   always_comb begin
      free_idx = NULL_IDX;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_at_head = rsp_ff.at_head;
   assign rsp_new_id = rsp_ff.new_id;
   assign rsp_more_left = rsp_ff.more_left;
   assign rsp_msg_valid = rsp_ff.msg_valid;
   assign rsp_msg_kind = rsp_ff.msg_kind;
   assign rsp_destination = rsp_ff.destination;
   assign rsp_out_lat = rsp_ff.out_lat;
   assign rsp_out_lon = rsp_ff.out_lon;

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      head_in = head_ff;
      idc_in = idc_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      func_in = func_ff;
      key_in = key_ff;
      kind_in = kind_ff;
      lat_in = lat_ff;
      lon_in = lon_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      slot_in = slot_ff;
      steps_in = steps_ff;
      ent_in = ent_ff;
      rd_en = 1'b0;
      rd_addr = cur_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = slot_ff[AW-1:0];
      wr_data = new_ent;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_func;
               kind_in = req_cmd_kind;
               lat_in = req_lat_word;
               lon_in = req_lon_word;
               key_in = (req_func == cle_pkg::FUNC_INSERT)
                  ? ID_BITS'(req_after_id) : ID_BITS'(req_target_id);
               state_in = S_START;
            end
         end
         S_START: begin
            rsp_in = '0;
            rsp_in.destination = cle_pkg::DEST_NONE;
            steps_in = '0;
            state_in = S_OUT;
            unique case (func_ff)
               cle_pkg::FUNC_INSERT: begin
                  if (free_idx == NULL_IDX) begin
                     rsp_in.status = cle_pkg::ST_FULL;
                  end else begin
                     slot_in = free_idx;
                     idc_in = idc_ff + ID_BITS'(1);
                     rsp_in.new_id = cle_pkg::OUT_ID_W'(idc_ff);
                     if (head_v == NULL_IDX || last_ff == key_ff) begin
                        wr_en = 1'b1;
                        wr_addr = free_idx[AW-1:0];
                        wr_data = {idc_ff, kind_ff, lat_ff, lon_ff, head_v};
                        used_in[free_idx[AW-1:0]] = 1'b1;
                        head_in = free_idx;
                        rsp_in.at_head = 1'b1;
                        rsp_in.msg_valid = 1'b1;
                        rsp_in.out_lat = lat_ff;
                        rsp_in.out_lon = lon_ff;
                     end else begin
                        cur_in = head_v;
                        state_in = S_RD;
                     end
                  end
               end
               cle_pkg::FUNC_POP: begin
                  if (head_v == NULL_IDX) begin
                     rsp_in.status = cle_pkg::ST_EMPTY;
                     rsp_in.destination = cle_pkg::DEST_MASTER;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = head_v[AW-1:0];
                     cur_in = head_v;
                     state_in = S_POPW;
                  end
               end
               cle_pkg::FUNC_DELETE: begin
                  rsp_in.status = cle_pkg::ST_NOTFOUND;
                  if (head_v != NULL_IDX) begin
                     prev_in = head_v;
                     cur_in = head_v;
                     state_in = S_RD;
                  end
               end
               default: begin
                  used_in = '0;
                  head_in = NULL_IDX;
                  last_in = '0;
                  idc_in = ID_BITS'(1);
               end
            endcase
         end
         S_RD: begin
            rd_en = 1'b1;
            rd_addr = cur_ff[AW-1:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            steps_in = steps_ff + SW'(1);
            if (func_ff == cle_pkg::FUNC_INSERT) begin
               // Slot is still free in used_ff, so a link to it reads as null.
               if (rd_follow == NULL_IDX || rd_id == key_ff
                   || steps_ff == SW'(CAPACITY - 1)) begin
                  ent_in = rd_data;
                  state_in = S_WRN;
               end else begin
                  cur_in = rd_follow;
                  state_in = S_RD;
               end
            end else begin
               // Delete: first read is the head (skip compare), then candidates.
               if (steps_ff != '0 && rd_id == key_ff) begin
                  slot_in = rd_follow;
                  state_in = S_DELR;
               end else if (rd_follow == NULL_IDX || rd_follow == head_v
                            || steps_ff == SW'(CAPACITY)) begin
                  state_in = S_OUT;
               end else begin
                  prev_in = cur_ff;
                  cur_in = rd_follow;
                  state_in = S_RD;
               end
            end
         end
         S_WRN: begin
            // Link new slot behind cur, then cur to new slot.
            wr_en = 1'b1;
            wr_addr = slot_ff[AW-1:0];
            wr_data = {idc_ff - ID_BITS'(1), kind_ff, lat_ff, lon_ff,
                       (ent_ff[IW-1:0] == slot_ff) ? NULL_IDX : ent_ff[IW-1:0]};
            if (!valid_idx(ent_ff[IW-1:0], used_ff)) begin
               wr_data[IW-1:0] = NULL_IDX;
            end
            used_in[slot_ff[AW-1:0]] = 1'b1;
            ent_in = {ent_ff[EW-1:IW], slot_ff};
            state_in = S_DELW;
         end
         S_POPW: begin
            last_in = rd_id;
            used_in[cur_ff[AW-1:0]] = 1'b0;
            head_in = (rd_follow == cur_ff) ? NULL_IDX : rd_follow;
            if (rd_follow != NULL_IDX && rd_follow != cur_ff) begin
               rd_en = 1'b1;
               rd_addr = rd_follow[AW-1:0];
               state_in = S_POPN;
            end else begin
               head_in = NULL_IDX;
               state_in = S_OUT;
            end
         end
         S_POPN: begin
            rsp_in.more_left = 1'b1;
            rsp_in.msg_valid = 1'b1;
            rsp_in.msg_kind = rd_kind;
            rsp_in.destination = rd_kind ? cle_pkg::DEST_CAM : cle_pkg::DEST_NAV;
            rsp_in.out_lat = rd_kind ? '0 : rd_lat;
            rsp_in.out_lon = rd_kind ? '0 : rd_lon;
            state_in = S_OUT;
         end
         S_DELR: begin
            rd_en = 1'b1;
            rd_addr = prev_ff[AW-1:0];
            used_in[cur_ff[AW-1:0]] = 1'b0;
            rsp_in.status = cle_pkg::ST_DONE;
            cur_in = prev_ff;
            state_in = S_DELW;
            ent_in = {rd_data[EW-1:IW], slot_ff};
            prev_in = NULL_IDX;
         end
         S_DELW: begin
            // Rewrite predecessor with its new next link.
            wr_en = 1'b1;
            wr_addr = cur_ff[AW-1:0];
            if (prev_ff == NULL_IDX) begin
               wr_data = {rd_data[EW-1:IW], ent_ff[IW-1:0]};
            end else begin
               wr_data = ent_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         head_ff <= NULL_IDX;
         idc_ff <= ID_BITS'(1);
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         head_ff <= head_in;
         idc_ff <= idc_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      func_ff <= func_in;
      key_ff <= key_in;
      kind_ff <= kind_in;
      lat_ff <= lat_in;
      lon_ff <= lon_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      slot_ff <= slot_in;
      steps_ff <= steps_in;
      ent_ff <= ent_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result shown while item just accepted");
   a_rsp_only_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output step");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en || rd_addr != wr_addr || state_ff == S_START)
      else $error("read and write of one entry collide");
endmodule

// File: design/cle_store.sv
// Entry memory of the command list: one synchronous read port, one write port.
module cle_store #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF,
   parameter int ID_BITS = cle_pkg::ID_BITS_DEF,
   localparam int IW = $clog2(CAPACITY + 1),
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int EW = ID_BITS + 1 + 2 * cle_pkg::COORD_W + IW
) (
   input logic clock,
   input logic rd_en,
   input logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   input logic wr_en,
   input logic [AW-1:0] wr_addr,
   input logic [EW-1:0] wr_data
);
   logic [EW-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
